// ===== design/til_pkg.sv =====
// Shared types, codes and constants for the table interpolated linearizer.
package til_pkg;

    localparam int DEFAULT_TABLE_DEPTH = 256;
    localparam int VAL_W               = 24;
    localparam int FRAC_W              = 8;
    localparam int COUNT_W             = 9;

    localparam logic REQ_WRITE   = 1'b0;
    localparam logic REQ_CONVERT = 1'b1;

    localparam logic [1:0] STATUS_OK    = 2'd0;
    localparam logic [1:0] STATUS_UNDER = 2'd1;
    localparam logic [1:0] STATUS_OVER  = 2'd2;

    typedef struct packed {
        logic              req_type;
        logic [7:0]        entry_index;
        logic [VAL_W-1:0]  entry_value;
        logic [VAL_W-1:0]  sample;
    } in_t;

    typedef struct packed {
        logic [1:0]  status;
        logic [15:0] position;
    } out_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_WRITE,
        ST_SCAN,
        ST_EVAL,
        ST_DIV
    } state_t;

endpackage

// ===== design/til_cell.sv =====
// One breakpoint cell of the rotating table ring.
module til_cell
    import til_pkg::*;
#(
    parameter int W = VAL_W
) (
    input  logic         clk,
    input  logic [W-1:0] din,
    input  logic         wr_en,
    input  logic [W-1:0] wr_data,
    output logic [W-1:0] q
);

    logic [W-1:0] q_reg;
    logic [W-1:0] q_next;

    // The cell takes its neighbor's entry every cycle unless a new entry is loaded.
    assign q_next = wr_en ? wr_data : din;

    always_ff @(posedge clk)
    begin
        q_reg <= q_next;
    end

    assign q = q_reg;

endmodule

// ===== design/til_div.sv =====
// Restoring divider that yields a short quotient, one bit per cycle.
module til_div
    import til_pkg::*;
#(
    parameter int W  = VAL_W,
    parameter int QW = FRAC_W
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    input  logic [W-1:0]  num,
    input  logic [W-1:0]  den,
    output logic          done,
    output logic [QW-1:0] quot
);

    localparam int CW = (QW > 1) ? $clog2(QW) : 1;

    logic          active_reg;
    logic          done_reg;
    logic [CW-1:0] cnt_reg;
    logic [W-1:0]  rem_reg;
    logic [W-1:0]  rem_next;
    logic [W-1:0]  den_reg;
    logic [QW-1:0] quot_reg;
    logic [W:0]    shifted;
    logic [W:0]    diff;
    logic          ge;

    // The remainder always stays below the divisor, so one shift and one subtract per bit.
    assign shifted  = {rem_reg, 1'b0};
    assign diff     = shifted - {1'b0, den_reg};
    assign ge       = (shifted >= {1'b0, den_reg});
    assign rem_next = ge ? diff[W-1:0] : shifted[W-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg <= 1'b0;
            done_reg   <= 1'b0;
            cnt_reg    <= '0;
        end
        else
        begin
            if (start)
            begin
                active_reg <= 1'b1;
                cnt_reg    <= '0;
                done_reg   <= 1'b0;
            end
            else if (active_reg)
            begin
                cnt_reg  <= cnt_reg + 1'b1;
                done_reg <= (cnt_reg == CW'(QW - 1));
                if (cnt_reg == CW'(QW - 1))
                begin
                    active_reg <= 1'b0;
                end
            end
            else
            begin
                done_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg  <= num;
            den_reg  <= den;
            quot_reg <= '0;
        end
        else if (active_reg)
        begin
            rem_reg  <= rem_next;
            quot_reg <= {quot_reg[QW-2:0], ge};
        end
    end

    assign done = done_reg;
    assign quot = quot_reg;

endmodule

// ===== design/table_interpolated_linearizer.sv =====
// Top level of the table interpolated linearizer: rotating breakpoint ring and search control.
//
//  Channel   Signals                        Handshake
//  --------  -----------------------------  -------------------------------------------
//  request   start, busy, request (in_t)    taken when start is high and busy is low
//  result    done, result (out_t)           valid for the single cycle that done is high
//  config    cfg_valid, cfg_ready, cfg_data written when cfg_valid and cfg_ready are high
//
// The breakpoint table lives in a ring of TABLE_DEPTH cells that rotates by one cell every
// cycle, so the entry index held in the first cell advances once per clock.
// A write request waits until its entry comes around.
// A convert request scans the whole ring once, then takes a decision step and, when the
// sample lies strictly between two breakpoints, runs the bit-serial divider.
// Reset clears the control state and sets entries_used to 256; the table itself is undefined
// until written. The receiver cannot stall: done flags each result for one cycle only.
module table_interpolated_linearizer
    import til_pkg::*;
#(
    parameter int TABLE_DEPTH = DEFAULT_TABLE_DEPTH
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  in_t                request,
    output logic               done,
    output out_t               result,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [COUNT_W-1:0] cfg_data
);

    localparam int IW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam logic [COUNT_W-1:0] DEPTH_N = COUNT_W'(TABLE_DEPTH);
    localparam logic [COUNT_W-1:0] MIN_N   = COUNT_W'(2);

    state_t state_reg;
    state_t state_next;

    in_t                req_reg;
    logic [COUNT_W-1:0] entries_used_reg;
    logic [COUNT_W-1:0] n_eff;
    logic [COUNT_W-1:0] n_eff_m1;
    logic [IW-1:0]      last_idx;

    logic [IW-1:0]      rot_reg;
    logic [IW-1:0]      rot_next;
    logic [IW-1:0]      scan_cnt_reg;
    logic               scan_last;

    logic [VAL_W-1:0]   cell_q [TABLE_DEPTH];
    logic [VAL_W-1:0]   cur_val;
    logic [VAL_W-1:0]   prev_val;

    logic               found_reg;
    logic               under_reg;
    logic               over_reg;
    logic [IW-1:0]      best_reg;
    logic [IW-1:0]      best_m1;
    logic [VAL_W-1:0]   lo_reg;
    logic [VAL_W-1:0]   hi_reg;
    logic               cand;

    logic               accept;
    logic               wr_in_range;
    logic               wr_hit;
    logic               wr_load;
    logic               finish;
    logic               div_start;
    logic               div_done;
    logic [FRAC_W-1:0]  div_quot;

    out_t               result_reg;
    out_t               result_next;
    logic               done_reg;

    assign busy      = (state_reg != ST_IDLE);
    assign accept    = start && !busy;
    assign cfg_ready = !busy;

    // The entry count in use is held between two and the table depth.
    always_comb
    begin
        n_eff = entries_used_reg;
        if (entries_used_reg < MIN_N)
        begin
            n_eff = MIN_N;
        end
        else if (entries_used_reg > DEPTH_N)
        begin
            n_eff = DEPTH_N;
        end
    end

    assign n_eff_m1 = n_eff - 1'b1;
    assign last_idx = n_eff_m1[IW-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            entries_used_reg <= COUNT_W'(256);
        end
        else if (cfg_valid && cfg_ready)
        begin
            entries_used_reg <= cfg_data;
        end
    end

    // Ring of breakpoint cells. The first cell holds the entry whose index is rot_reg; the
    // last cell holds the entry that moves into the first cell at the next edge.
    assign rot_next = (rot_reg == IW'(TABLE_DEPTH - 1)) ? '0 : rot_reg + 1'b1;

    generate
        for (genvar k = 0; k < TABLE_DEPTH; k++)
        begin : g_ring
            if (k == 0)
            begin : g_head
                til_cell #(.W(VAL_W)) u_cell (
                    .clk     (clk),
                    .din     (cell_q[TABLE_DEPTH-1]),
                    .wr_en   (wr_load),
                    .wr_data (req_reg.entry_value),
                    .q       (cell_q[0])
                );
            end
            else
            begin : g_body
                til_cell #(.W(VAL_W)) u_cell (
                    .clk     (clk),
                    .din     (cell_q[k-1]),
                    .wr_en   (1'b0),
                    .wr_data (req_reg.entry_value),
                    .q       (cell_q[k])
                );
            end
        end
    endgenerate

    // The first cell carries entry rot_reg and the second carries its predecessor.
    assign cur_val  = cell_q[0];
    assign prev_val = cell_q[1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rot_reg <= '0;
        end
        else
        begin
            rot_reg <= rot_next;
        end
    end

    // A write lands when its entry is about to enter the first cell.
    assign wr_in_range = ({1'b0, req_reg.entry_index} < DEPTH_N);
    assign wr_hit      = wr_in_range && (8'(rot_next) == req_reg.entry_index);

    // During the scan every entry passes the first cell once. The lowest in-use index whose
    // breakpoint is not below the sample wins, together with the entry just before it.
    assign scan_last = (scan_cnt_reg == IW'(TABLE_DEPTH - 1));
    assign cand      = (rot_reg <= last_idx) && (req_reg.sample <= cur_val) &&
                       (!found_reg || (rot_reg < best_reg));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            scan_cnt_reg <= '0;
            found_reg    <= 1'b0;
            under_reg    <= 1'b0;
            over_reg     <= 1'b0;
            done_reg     <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= finish;
            if (accept)
            begin
                scan_cnt_reg <= '0;
                found_reg    <= 1'b0;
                under_reg    <= 1'b0;
                over_reg     <= 1'b0;
            end
            else if (state_reg == ST_SCAN)
            begin
                scan_cnt_reg <= scan_cnt_reg + 1'b1;
                if (cand)
                begin
                    found_reg <= 1'b1;
                end
                if ((rot_reg == '0) && (req_reg.sample < cur_val))
                begin
                    under_reg <= 1'b1;
                end
                if ((rot_reg == last_idx) && (req_reg.sample > cur_val))
                begin
                    over_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            req_reg <= request;
        end
        if ((state_reg == ST_SCAN) && cand)
        begin
            best_reg <= rot_reg;
            hi_reg   <= cur_val;
            lo_reg   <= prev_val;
        end
        if (finish)
        begin
            result_reg <= result_next;
        end
    end

    assign best_m1 = best_reg - 1'b1;

    // Fraction between the two bracketing breakpoints.
    til_div #(.W(VAL_W), .QW(FRAC_W)) u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (req_reg.sample - lo_reg),
        .den   (hi_reg - lo_reg),
        .done  (div_done),
        .quot  (div_quot)
    );

    // Next-state logic.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = (request.req_type == REQ_WRITE) ? ST_WRITE : ST_SCAN;
                end
            end
            ST_WRITE:
            begin
                if (finish)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_SCAN:
            begin
                if (scan_last)
                begin
                    state_next = ST_EVAL;
                end
            end
            ST_EVAL:
            begin
                state_next = finish ? ST_IDLE : ST_DIV;
            end
            ST_DIV:
            begin
                if (finish)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Output and control logic.
    always_comb
    begin
        wr_load              = 1'b0;
        finish               = 1'b0;
        div_start            = 1'b0;
        result_next.status   = STATUS_OK;
        result_next.position = '0;
        case (state_reg)
            ST_WRITE:
            begin
                wr_load = wr_hit;
                finish  = wr_hit || !wr_in_range;
            end
            ST_EVAL:
            begin
                if (under_reg)
                begin
                    finish             = 1'b1;
                    result_next.status = STATUS_UNDER;
                end
                else if (over_reg)
                begin
                    finish             = 1'b1;
                    result_next.status = STATUS_OVER;
                end
                else if ((req_reg.sample == hi_reg) || (best_reg == '0))
                begin
                    finish               = 1'b1;
                    result_next.position = {8'(best_reg), 8'd0};
                end
                else if ((hi_reg <= lo_reg) || (req_reg.sample <= lo_reg))
                begin
                    finish               = 1'b1;
                    result_next.position = {8'(best_m1), 8'd0};
                end
                else
                begin
                    div_start = 1'b1;
                end
            end
            ST_DIV:
            begin
                if (div_done)
                begin
                    finish               = 1'b1;
                    result_next.position = {8'(best_m1), div_quot};
                end
            end
            default:
            begin
            end
        endcase
    end

    assign done   = done_reg;
    assign result = result_reg;

    // A result only follows a cycle in which a request was still being worked on.
    a_done_after_work: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(state_reg != ST_IDLE))
        else $error("result strobe without a request in progress");

    // Out-of-range conversions never report a position.
    a_flag_no_position: assert property (@(posedge clk) disable iff (!rst_n)
        (done && (result.status != STATUS_OK)) |-> (result.position == '0))
        else $error("flagged result carries a position");

    // The divider is only entered from the decision step.
    a_div_entry: assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == ST_DIV) && ($past(state_reg) != ST_DIV)) |->
        ($past(state_reg) == ST_EVAL))
        else $error("divider entered outside the decision step");

    // A convert request always sweeps the full ring before deciding.
    a_scan_full: assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == ST_EVAL) && ($past(state_reg) == ST_SCAN)) |->
        ($past(scan_cnt_reg) == IW'(TABLE_DEPTH - 1)))
        else $error("scan left the ring before a full turn");

endmodule

// ===== tb/tb_table_interpolated_linearizer.sv =====
// Testbench for the table interpolated linearizer: breakpoint writes and conversions checked against a built-in predictor.
`timescale 1ns / 1ps

module tb_table_interpolated_linearizer;
    import til_pkg::*;

    localparam int CLK_PERIOD    = 20;
    localparam int RESET_CYCLES  = 12;
    // A conversion sweeps the ring once and may then run the divider, and the longest sender gap
    // is about as long as a sweep, so a quiet stretch that reaches WATCHDOG_LIMIT can only mean a hang.
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int TAIL_CYCLES    = DEFAULT_TABLE_DEPTH + 40;
    localparam int SETTLE_CYCLES  = 4;
    localparam logic [VAL_W-1:0] VAL_MAX = '1;

    logic               clk;
    logic               rst_n;
    logic               start;
    logic               busy;
    in_t                request;
    logic               done;
    out_t               result;
    logic               cfg_valid;
    logic               cfg_ready;
    logic [COUNT_W-1:0] cfg_data;

    // Shadow of the block's state: the breakpoint table and the entry count register.
    logic [VAL_W-1:0]   breakpoints [DEFAULT_TABLE_DEPTH];
    logic [COUNT_W-1:0] entries_used_shadow;

    // Results owed by the block, oldest first.
    out_t        expected_results [$];
    int          error_count;
    int unsigned sender_idle_pct;
    int          idle_cycles;

    table_interpolated_linearizer #(
        .TABLE_DEPTH(DEFAULT_TABLE_DEPTH)
    ) u_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (start),
        .busy     (busy),
        .request  (request),
        .done     (done),
        .result   (result),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_data (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #(CLK_PERIOD / 2) clk = ~clk;
    end

    // The register is clamped into the range from two entries up to the full table depth.
    function automatic int unsigned entries_in_use();
        if (entries_used_shadow < 2)
        begin
            return 2;
        end
        if (entries_used_shadow > DEFAULT_TABLE_DEPTH)
        begin
            return DEFAULT_TABLE_DEPTH;
        end
        return entries_used_shadow;
    endfunction

    // Computes the result that one request produces and applies its effect on the table.
    // A write stores the breakpoint and answers OK with position zero. A conversion flags
    // samples outside the table in use, otherwise walks to the first breakpoint not below
    // the sample and interpolates between it and the one before.
    function automatic out_t linearize_request(input in_t item);
        out_t                    res;
        int unsigned             n;
        int unsigned             pos;
        logic [VAL_W-1:0]        lo;
        logic [VAL_W-1:0]        hi;
        logic [VAL_W+FRAC_W-1:0] frac;
        res.status   = STATUS_OK;
        res.position = '0;
        if (item.req_type == REQ_WRITE)
        begin
            breakpoints[item.entry_index] = item.entry_value;
            return res;
        end
        n = entries_in_use();
        if (item.sample < breakpoints[0])
        begin
            res.status = STATUS_UNDER;
        end
        else if (item.sample > breakpoints[n - 1])
        begin
            res.status = STATUS_OVER;
        end
        else
        begin
            pos = 0;
            while (pos < n - 1 && item.sample > breakpoints[pos])
            begin
                pos++;
            end
            if (item.sample == breakpoints[pos] || pos == 0)
            begin
                res.position = 16'(pos << FRAC_W);
            end
            else
            begin
                lo = breakpoints[pos - 1];
                hi = breakpoints[pos];
                if (hi <= lo || item.sample <= lo)
                begin
                    res.position = 16'((pos - 1) << FRAC_W);
                end
                else
                begin
                    // Fraction of the step between the two breakpoints, truncated.
                    frac = {item.sample - lo, {FRAC_W{1'b0}}} / {{FRAC_W{1'b0}}, hi - lo};
                    if (frac > 255)
                    begin
                        frac = 255;
                    end
                    res.position = 16'(((pos - 1) << FRAC_W) + frac);
                end
            end
        end
        return res;
    endfunction

    // A request with every field random; callers overwrite the fields that matter.
    function automatic in_t random_request();
        in_t item;
        item.req_type    = 1'($urandom());
        item.entry_index = 8'($urandom());
        item.entry_value = VAL_W'($urandom());
        item.sample      = VAL_W'($urandom());
        return item;
    endfunction

    function automatic in_t make_write(input logic [7:0] index, input logic [VAL_W-1:0] value);
        in_t item;
        item             = random_request();
        item.req_type    = REQ_WRITE;
        item.entry_index = index;
        item.entry_value = value;
        return item;
    endfunction

    function automatic in_t make_convert(input logic [VAL_W-1:0] value);
        in_t item;
        item          = random_request();
        item.req_type = REQ_CONVERT;
        item.sample   = value;
        return item;
    endfunction

    // Holds start low for a random number of cycles. Besides the per-cycle idle chance, an
    // occasional long gap lets the next request land at any point of the ring's rotation.
    // The request bus carries random values while start is low.
    task automatic sender_pause(input int unsigned idle_pct);
        int unsigned gap;
        gap = 0;
        while ($urandom_range(99, 0) < idle_pct)
        begin
            gap++;
        end
        if (idle_pct != 0 && $urandom_range(7, 0) == 0)
        begin
            gap += $urandom_range(DEFAULT_TABLE_DEPTH + 12, 1);
        end
        if (gap != 0)
        begin
            start   <= 1'b0;
            request <= random_request();
            repeat (gap) @(posedge clk);
        end
    endtask

    // Presents one request and holds it until the block takes it, then pauses. Start stays high
    // when the pause is empty, so that back-to-back requests never drop it for a cycle.
    task automatic send_request(input in_t item);
        start   <= 1'b1;
        request <= item;
        do
        begin
            @(posedge clk);
        end
        while (busy !== 1'b0);
        expected_results.push_back(linearize_request(item));
        sender_pause(sender_idle_pct);
    endtask

    // Stops sending and waits until every owed result has come back. Every request yields
    // exactly one result, so the block is idle once the queue is empty.
    task automatic drain_results();
        start <= 1'b0;
        while (expected_results.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // The entry count is only changed while the block is idle.
    task automatic write_entries_used(input logic [COUNT_W-1:0] count);
        drain_results();
        cfg_valid <= 1'b1;
        cfg_data  <= count;
        do
        begin
            @(posedge clk);
        end
        while (cfg_ready !== 1'b1);
        cfg_valid           <= 1'b0;
        entries_used_shadow  = count;
    endtask

    // Two- and three-entry tables: both range flags, exact hits on either end, the smallest
    // and a middle fraction, zero and all-ones values, a flat table, a table that falls
    // before it rises, and entry counts below two that must act as two.
    task automatic test_small_table_edges();
        write_entries_used(9'd2);
        send_request(make_write(8'd0, 24'h000100));
        send_request(make_write(8'd1, VAL_MAX));
        send_request(make_write(8'd255, 24'h123456));
        send_request(make_convert(24'h000000));
        send_request(make_convert(24'h0000FF));
        send_request(make_convert(24'h000100));
        send_request(make_convert(VAL_MAX));
        send_request(make_convert(24'h000101));
        send_request(make_convert(24'h800000));

        send_request(make_write(8'd1, 24'h000200));
        send_request(make_convert(VAL_MAX));
        send_request(make_convert(24'h000201));
        send_request(make_convert(24'h000180));

        // Zero breakpoint, then a flat table where both entries are equal.
        send_request(make_write(8'd0, 24'h000000));
        send_request(make_convert(24'h000000));
        send_request(make_write(8'd1, 24'h000000));
        send_request(make_convert(24'h000000));
        send_request(make_convert(24'h000001));

        write_entries_used(9'd0);
        send_request(make_write(8'd1, 24'h000300));
        send_request(make_convert(24'h000200));
        write_entries_used(9'd1);
        send_request(make_convert(24'h000300));

        // A table that dips at entry one: the walk still stops at the first entry not below.
        write_entries_used(9'd3);
        send_request(make_write(8'd0, 24'h000A00));
        send_request(make_write(8'd1, 24'h000500));
        send_request(make_write(8'd2, 24'h001400));
        send_request(make_convert(24'h000F00));
        send_request(make_convert(24'h000A00));
        send_request(make_convert(24'h000C00));
    endtask

    // Loads all 256 breakpoints in shuffled order as a rising table that ends at the top of the
    // value range, then probes the ends and inner breakpoints with the full count and with counts above it.
    task automatic test_full_table();
        int unsigned      order [DEFAULT_TABLE_DEPTH];
        int unsigned      j;
        int unsigned      swap;
        logic [VAL_W-1:0] value;
        write_entries_used(9'd256);
        foreach (order[i])
        begin
            order[i] = i;
        end
        for (int i = DEFAULT_TABLE_DEPTH - 1; i > 0; i--)
        begin
            j        = $urandom_range(i, 0);
            swap     = order[i];
            order[i] = order[j];
            order[j] = swap;
        end
        foreach (order[k])
        begin
            if (order[k] == DEFAULT_TABLE_DEPTH - 1)
            begin
                value = VAL_MAX;
            end
            else
            begin
                value = VAL_W'(order[k] * 32'h10000 + $urandom_range(16'hFFFF, 1));
            end
            send_request(make_write(8'(order[k]), value));
        end
        send_request(make_convert(24'h000000));
        send_request(make_convert(VAL_MAX));
        send_request(make_convert(breakpoints[128]));
        send_request(make_convert(breakpoints[200] + 24'd1));

        // Counts above the table depth act as the full table.
        write_entries_used(9'd511);
        send_request(make_convert(VAL_MAX));
        send_request(make_convert(breakpoints[254] + 24'd1));
        write_entries_used(9'd300);
        send_request(make_convert(VAL_W'($urandom())));
    endtask

    // Bursts of mixed traffic, each behind a fresh entry count. Most writes keep the table
    // rising; a few store arbitrary values or touch entries outside the part in use. Samples
    // are drawn mostly from inside the table so that the walk and the interpolation get
    // exercised, with range misses, exact hits and fully random values mixed in. Every
    // count change first lets all owed results come back.
    task automatic test_random_traffic(input int unsigned num_items);
        int unsigned      sent;
        int unsigned      burst;
        int unsigned      n;
        int unsigned      idx;
        int unsigned      pick;
        logic [VAL_W-1:0] lo;
        logic [VAL_W-1:0] hi;
        in_t              item;
        sent = 0;
        while (sent < num_items)
        begin
            case ($urandom_range(9, 0))
                0:       write_entries_used(9'd2);
                1:       write_entries_used(9'd256);
                2:       write_entries_used(COUNT_W'($urandom_range(511, 257)));
                3:       write_entries_used(COUNT_W'($urandom_range(1, 0)));
                default: write_entries_used(COUNT_W'($urandom_range(24, 3)));
            endcase
            n     = entries_in_use();
            burst = $urandom_range(24, 12);
            repeat (burst)
            begin
                item = random_request();
                pick = $urandom_range(99, 0);
                if (pick < 25)
                begin
                    item.req_type    = REQ_WRITE;
                    idx              = (pick < 6) ? $urandom_range(255, 0)
                                                  : $urandom_range(n - 1, 0);
                    item.entry_index = 8'(idx);
                    lo = (idx == 0) ? '0 : breakpoints[idx - 1];
                    hi = (idx == DEFAULT_TABLE_DEPTH - 1) ? VAL_MAX : breakpoints[idx + 1];
                    // The lowest picks keep their random value and may break the order.
                    if (pick >= 3)
                    begin
                        item.entry_value = (hi > lo + 1) ? VAL_W'($urandom_range(hi - 1, lo + 1))
                                                         : breakpoints[idx];
                    end
                end
                else
                begin
                    item.req_type = REQ_CONVERT;
                    idx = $urandom_range(n - 2, 0);
                    lo  = breakpoints[idx];
                    hi  = breakpoints[idx + 1];
                    if (pick < 33)
                    begin
                        item.sample = (breakpoints[0] == '0) ? '0
                            : VAL_W'($urandom_range(breakpoints[0] - 1, 0));
                    end
                    else if (pick < 41)
                    begin
                        item.sample = (breakpoints[n - 1] == VAL_MAX) ? VAL_MAX
                            : VAL_W'($urandom_range(VAL_MAX, breakpoints[n - 1] + 1));
                    end
                    else if (pick < 55)
                    begin
                        item.sample = breakpoints[idx + $urandom_range(1, 0)];
                    end
                    else if (pick < 92)
                    begin
                        item.sample = (hi >= lo) ? VAL_W'($urandom_range(hi, lo))
                                                 : VAL_W'($urandom_range(lo, hi));
                    end
                end
                send_request(item);
                sent++;
            end
        end
    endtask

    // Every result is compared against the oldest owed one. Outputs are read right after
    // the edge, before any register in the block has taken its new value.
    always @(posedge clk)
    begin : result_check
        out_t expected;
        logic bad_status;
        logic bad_position;
        if (rst_n && done === 1'b1)
        begin
            if (expected_results.size() == 0)
            begin
                error_count++;
                $display("%0t: result with none owed: status=%0d position=0x%04h",
                         $time, result.status, result.position);
            end
            else
            begin
                expected     = expected_results.pop_front();
                bad_status   = (result.status !== expected.status);
                bad_position = (result.position !== expected.position);
                if (bad_status || bad_position)
                begin
                    error_count++;
                    $display("%0t: mismatch: expected status=%0d position=0x%04h, got status=%0d position=0x%04h",
                             $time, expected.status, expected.position,
                             result.status, result.position);
                end
            end
        end
    end

    // Ends the run if nothing moves on any channel for too long.
    always @(posedge clk)
    begin
        if (!rst_n || (start && !busy) || done || (cfg_valid && cfg_ready))
        begin
            idle_cycles <= 0;
        end
        else if (idle_cycles + 1 >= WATCHDOG_LIMIT)
        begin
            $display("DONE: errors detected");
            $finish;
        end
        else
        begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial
    begin
        start               <= 1'b0;
        request             <= '0;
        cfg_valid           <= 1'b0;
        cfg_data            <= '0;
        rst_n               <= 1'b0;
        idle_cycles         <= 0;
        error_count          = 0;
        entries_used_shadow  = 9'd256;
        sender_idle_pct      = 16;

        // Reset is released away from the rising edge.
        repeat (RESET_CYCLES) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_small_table_edges();
        test_full_table();
        test_random_traffic(80);
        sender_idle_pct = 46;
        test_random_traffic(80);
        sender_idle_pct = 0;
        test_random_traffic(80);

        drain_results();
        repeat (TAIL_CYCLES) @(posedge clk);
        if (error_count == 0 && expected_results.size() == 0)
        begin
            $display("DONE: 0 errors");
        end
        else
        begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule

// ===== files.f =====
design/til_pkg.sv
design/til_cell.sv
design/til_div.sv
design/table_interpolated_linearizer.sv
tb/tb_table_interpolated_linearizer.sv
